FILE: hw/rtl/spd_pkg.sv
// Shared constants and control/status types for the shortest path block.
package spd_pkg;

    localparam int NODE_W   = 5;
    localparam int DIST_W   = 21;
    localparam int WIN_W    = 16;
    localparam int OP_W     = 2;
    localparam int MAX_RES  = 32;
    localparam logic [DIST_W-1:0] DIST_MAX = 21'h1FFFFF;

    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    typedef struct packed {
        logic clr_write;
        logic edge_write;
        logic query_load;
        logic cnt_clr;
        logic best_clr;
        logic issue;
        logic relax;
        logic visit;
        logic path_init;
        logic path_read;
        logic path_wait;
        logic out_load;
        logic out_unr;
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            qok;
        logic            found;
        logic            dest_known;
        logic            clr_last;
        logic            scan_last;
        logic            out_free;
        logic            path_last;
    } st_t;

endpackage

FILE: hw/rtl/spd_in_if.sv
// Input channel: edge and query items.
interface spd_in_if;
    import spd_pkg::*;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic [WIN_W-1:0]  weight;

    modport source (output valid, op, node_a, node_b, weight, input ready);
    modport sink   (input valid, op, node_a, node_b, weight, output ready);
endinterface

FILE: hw/rtl/spd_out_if.sv
// Output channel: path node items.
interface spd_out_if;
    import spd_pkg::*;
    logic              valid;
    logic              ready;
    logic [NODE_W-1:0] path_node;
    logic [DIST_W-1:0] total_distance;
    logic              reachable;
    logic              last;

    modport source (output valid, path_node, total_distance, reachable, last, input ready);
    modport sink   (input valid, path_node, total_distance, reachable, last, output ready);
endinterface

FILE: hw/rtl/shortest_path_dijkstra.sv
// Top level: shortest path search engine over a stored weighted edge matrix.
// Channel in carries items {op, node_a, node_b, weight}: op clear empties the
// edge matrix, op write sets edge node_a -> node_b, op query searches from
// node_a to node_b. Channel out returns one item per path node, destination
// first, each with total_distance and reachable; last marks the final one.
// Edge write: stored as it is accepted. Clear: a sweep over all NODE_COUNT^2
// entries (rounded up to a power of two per dimension), one entry per cycle.
// Query: each search step scans all N nodes for the minimum distance (states
// S_SCAN, S_PICK, S_DECIDE) and reads the winner's matrix row (S_RELAX,
// S_RDRAIN); steps run one after another over the single read port of the
// edge and node memories. A path item passes S_PATH_RD, S_PATH_WAIT, S_EMIT.
// One item is in work at a time; in.ready is high only while the engine is
// idle. Results sit in an output register; a stalled receiver holds the
// search at the next output step, and the next item is accepted while the
// final result still waits.
// After reset the same clearing sweep runs before the first item is taken.
module shortest_path_dijkstra #(
    parameter int NODE_COUNT  = 32,
    parameter int WEIGHT_BITS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    spd_in_if.sink    in,
    spd_out_if.source out
);
    import spd_pkg::*;

    cmd_t cmd;
    st_t  st;
    logic in_ready;

    assign in.ready = in_ready;

    spd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in.valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    spd_dp #(
        .NODE_COUNT  (NODE_COUNT),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (in),
        .out   (out),
        .cmd   (cmd),
        .st    (st)
    );

endmodule

FILE: hw/rtl/spd_dp.sv
// Datapath: edge matrix memory, node distance memory, scan/relax pipeline, output register.
module spd_dp #(
    parameter int NODE_COUNT  = 32,
    parameter int WEIGHT_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    spd_in_if.sink        in,
    spd_out_if.source     out,
    input  spd_pkg::cmd_t cmd,
    output spd_pkg::st_t  st
);
    import spd_pkg::*;

    localparam int NB         = $clog2(NODE_COUNT);
    localparam int EA         = 2 * NB;
    localparam int EDGE_DEPTH = 1 << EA;
    localparam int NW         = DIST_W + NB;
    localparam int EW         = WEIGHT_BITS + 1;
    localparam logic [NB-1:0] LAST_IDX = NB'(NODE_COUNT - 1);
    localparam logic [6:0]    NODE_LIM = 7'(NODE_COUNT);
    localparam logic [NODE_W-1:0] LAST_RES = NODE_W'(MAX_RES - 1);

    logic [EW-1:0] edge_mem [EDGE_DEPTH];
    logic [NW-1:0] node_mem [NODE_COUNT];

    logic [EA-1:0]         cnt_reg;
    logic [NB-1:0]         start_reg;
    logic [NB-1:0]         dest_reg;
    logic [NODE_W-1:0]     dest_raw_reg;
    logic                  qok_reg;
    logic [NODE_COUNT-1:0] known_reg;
    logic [NODE_COUNT-1:0] visited_reg;
    logic                  p_vld_reg;
    logic                  p_relax_reg;
    logic [NB-1:0]         p_idx_reg;
    logic [EW-1:0]         e_rd_reg;
    logic [NW-1:0]         n_rd_reg;
    logic [NB-1:0]         best_idx_reg;
    logic [DIST_W-1:0]     best_dist_reg;
    logic                  found_reg;
    logic [NB-1:0]         cur_reg;
    logic [NODE_W-1:0]     k_reg;
    logic [DIST_W-1:0]     total_reg;
    logic                  out_valid_reg;
    logic [NODE_W-1:0]     out_node_reg;
    logic [DIST_W-1:0]     out_dist_reg;
    logic                  out_reach_reg;
    logic                  out_last_reg;

    logic                   a_ok, b_ok;
    logic [NB-1:0]          a_idx, b_idx;
    logic [WEIGHT_BITS-1:0] w_in;
    logic                   e_valid;
    logic [WEIGHT_BITS-1:0] e_w;
    logic [32:0]            alt_full;
    logic [DIST_W-1:0]      alt;
    logic [DIST_W-1:0]      n_dist;
    logic [NB-1:0]          n_pred;
    logic                   relax_we;
    logic                   scan_hit;
    logic                   init_we;
    logic [NB-1:0]          n_rd_addr;
    logic                   path_last;
    logic                   out_free;

    assign a_ok  = {2'b00, in.node_a} < NODE_LIM;
    assign b_ok  = {2'b00, in.node_b} < NODE_LIM;
    assign a_idx = NB'(in.node_a);
    assign b_idx = NB'(in.node_b);
    assign w_in  = WEIGHT_BITS'(in.weight);

    assign e_valid  = e_rd_reg[EW-1];
    assign e_w      = e_rd_reg[WEIGHT_BITS-1:0];
    assign n_dist   = n_rd_reg[DIST_W-1:0];
    assign n_pred   = n_rd_reg[NW-1:DIST_W];
    assign alt_full = 33'(best_dist_reg) + 33'(e_w);
    assign alt      = (alt_full > 33'(DIST_MAX)) ? DIST_MAX : alt_full[DIST_W-1:0];

    assign relax_we = p_vld_reg && p_relax_reg && e_valid &&
                      (!known_reg[p_idx_reg] || alt < n_dist);
    assign scan_hit = p_vld_reg && !p_relax_reg && !visited_reg[p_idx_reg] &&
                      known_reg[p_idx_reg] && (!found_reg || n_dist < best_dist_reg);
    assign init_we  = cmd.query_load && a_ok && b_ok;
    assign n_rd_addr = cmd.issue ? cnt_reg[NB-1:0] : cur_reg;

    assign path_last = (cur_reg == start_reg) || (k_reg == LAST_RES);
    assign out_free  = !out_valid_reg || out.ready;

    // edge matrix, {valid, weight}, row = source node
    always_ff @(posedge clk)
    begin
        if (cmd.clr_write)
        begin
            edge_mem[cnt_reg] <= '0;
        end
        else if (cmd.edge_write && a_ok && b_ok)
        begin
            edge_mem[{a_idx, b_idx}] <= {1'b1, w_in};
        end
        if (cmd.issue)
        begin
            e_rd_reg <= edge_mem[{best_idx_reg, cnt_reg[NB-1:0]}];
        end
    end

    // node memory, {predecessor, distance}
    always_ff @(posedge clk)
    begin
        if (init_we)
        begin
            node_mem[a_idx] <= '0;
        end
        else if (relax_we)
        begin
            node_mem[p_idx_reg] <= {best_idx_reg, alt};
        end
        if (cmd.issue || cmd.path_read)
        begin
            n_rd_reg <= node_mem[n_rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            known_reg     <= '0;
            visited_reg   <= '0;
            p_vld_reg     <= 1'b0;
            p_relax_reg   <= 1'b0;
            found_reg     <= 1'b0;
            qok_reg       <= 1'b0;
            cur_reg       <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.cnt_clr)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.clr_write || cmd.issue)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end

            if (cmd.query_load)
            begin
                qok_reg     <= a_ok && b_ok;
                known_reg   <= NODE_COUNT'(1) << a_idx;
                visited_reg <= '0;
            end
            else
            begin
                if (relax_we)
                begin
                    known_reg[p_idx_reg] <= 1'b1;
                end
                if (cmd.visit)
                begin
                    visited_reg[best_idx_reg] <= 1'b1;
                end
            end

            p_vld_reg   <= cmd.issue;
            p_relax_reg <= cmd.relax;

            if (cmd.best_clr)
            begin
                found_reg <= 1'b0;
            end
            else if (scan_hit)
            begin
                found_reg <= 1'b1;
            end

            if (cmd.path_init)
            begin
                cur_reg <= dest_reg;
                k_reg   <= '0;
            end
            else if (cmd.out_load && !cmd.out_unr)
            begin
                cur_reg <= n_pred;
                k_reg   <= k_reg + 1'b1;
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        p_idx_reg <= cnt_reg[NB-1:0];
        if (cmd.query_load)
        begin
            start_reg    <= a_idx;
            dest_reg     <= b_idx;
            dest_raw_reg <= in.node_b;
        end
        if (scan_hit)
        begin
            best_idx_reg  <= p_idx_reg;
            best_dist_reg <= n_dist;
        end
        if (cmd.path_wait && k_reg == '0)
        begin
            total_reg <= n_dist;
        end
        if (cmd.out_load)
        begin
            out_node_reg  <= cmd.out_unr ? dest_raw_reg : NODE_W'(cur_reg);
            out_dist_reg  <= cmd.out_unr ? '0 : total_reg;
            out_reach_reg <= !cmd.out_unr;
            out_last_reg  <= cmd.out_unr || path_last;
        end
    end

    assign out.valid          = out_valid_reg;
    assign out.path_node      = out_node_reg;
    assign out.total_distance = out_dist_reg;
    assign out.reachable      = out_reach_reg;
    assign out.last           = out_last_reg;

    assign st.op         = in.op;
    assign st.qok        = qok_reg;
    assign st.found      = found_reg;
    assign st.dest_known = known_reg[dest_reg];
    assign st.clr_last   = &cnt_reg;
    assign st.scan_last  = cnt_reg[NB-1:0] == LAST_IDX;
    assign st.out_free   = out_free;
    assign st.path_last  = path_last;

endmodule

FILE: hw/rtl/spd_ctrl.sv
// Controller: sequences clear sweeps, edge writes, the search loop and path output.
module spd_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  spd_pkg::st_t  st,
    output spd_pkg::cmd_t cmd
);
    import spd_pkg::*;

    typedef enum logic [12:0] {
        S_CLEAR     = 13'b0000000000001,
        S_IDLE      = 13'b0000000000010,
        S_START     = 13'b0000000000100,
        S_SCAN      = 13'b0000000001000,
        S_PICK      = 13'b0000000010000,
        S_DECIDE    = 13'b0000000100000,
        S_RELAX     = 13'b0000001000000,
        S_RDRAIN    = 13'b0000010000000,
        S_FIN       = 13'b0000100000000,
        S_UNR       = 13'b0001000000000,
        S_PATH_RD   = 13'b0010000000000,
        S_PATH_WAIT = 13'b0100000000000,
        S_EMIT      = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_write = 1'b1;
                if (st.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (st.op)
                        OP_CLEAR:
                        begin
                            cmd.cnt_clr = 1'b1;
                            state_next  = S_CLEAR;
                        end
                        OP_WRITE:
                        begin
                            cmd.edge_write = 1'b1;
                        end
                        OP_QUERY:
                        begin
                            cmd.query_load = 1'b1;
                            state_next     = S_START;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_START:
            begin
                cmd.cnt_clr  = 1'b1;
                cmd.best_clr = 1'b1;
                state_next   = st.qok ? S_SCAN : S_UNR;
            end
            S_SCAN:
            begin
                cmd.issue = 1'b1;
                if (st.scan_last)
                begin
                    state_next = S_PICK;
                end
            end
            S_PICK:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (st.found)
                begin
                    cmd.visit   = 1'b1;
                    cmd.cnt_clr = 1'b1;
                    state_next  = S_RELAX;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_RELAX:
            begin
                cmd.issue = 1'b1;
                cmd.relax = 1'b1;
                if (st.scan_last)
                begin
                    state_next = S_RDRAIN;
                end
            end
            S_RDRAIN:
            begin
                cmd.cnt_clr  = 1'b1;
                cmd.best_clr = 1'b1;
                state_next   = S_SCAN;
            end
            S_FIN:
            begin
                if (st.dest_known)
                begin
                    cmd.path_init = 1'b1;
                    state_next    = S_PATH_RD;
                end
                else
                begin
                    state_next = S_UNR;
                end
            end
            S_UNR:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_unr  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_PATH_RD:
            begin
                cmd.path_read = 1'b1;
                state_next    = S_PATH_WAIT;
            end
            S_PATH_WAIT:
            begin
                cmd.path_wait = 1'b1;
                state_next    = S_EMIT;
            end
            S_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = st.path_last ? S_IDLE : S_PATH_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
